>>> hdl/elias_gamma_codec_defines.svh
// Assertion macros for the Elias gamma codec.
// Included by modules that carry concurrent checks; expects clk and rst_n in scope.
`ifndef ELIAS_GAMMA_CODEC_DEFINES_SVH
`define ELIAS_GAMMA_CODEC_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define EGC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define EGC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/egc_pkg.sv
// Shared types and constants for the Elias gamma codec.
// No dependencies.
package egc_pkg;

  localparam int OUT_W = 32;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  typedef enum logic [1:0] {
    ENC_IDLE,
    ENC_PREFIX,
    ENC_SUFFIX
  } enc_state_t;

endpackage

>>> hdl/elias_gamma_codec.sv
// Elias gamma codec top level, bit-serial encoder and decoder.
// Depends on egc_pkg and elias_gamma_codec_defines.svh.
//
// Encode items take a value x (low min(VALUE_WIDTH, 32) bits used) and stream 2q+1
// code items, q = floor(log2 x): q ones, a zero, then the q low bits of x LSB first,
// the last one flagged. The value is loaded, then one bit leaves per cycle from the
// shift registers while out_stall is low; the input stays stalled until the last
// bit has left. A zero value yields one error item. Decode items carry one code
// bit each and are taken one per cycle while in_stall is low; a finished codeword
// or a prefix of VALUE_WIDTH ones yields one item. Encode items leave decoder
// progress untouched. A single output register separates the two channels.
`include "elias_gamma_codec_defines.svh"

module elias_gamma_codec import egc_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_mode,
  input  logic [31:0]      in_value_in,
  input  logic             in_code_bit_in,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_code_bit_out,
  output logic             out_bit_valid,
  output logic             out_last_bit,
  output logic [OUT_W-1:0] out_decoded_value,
  output logic             out_value_valid,
  output logic             out_error
);

  localparam int EW = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  localparam int QW = $clog2(EW);
  localparam int PW = $clog2(VALUE_WIDTH);

  enc_state_t enc_state_r, enc_state_nxt;
  logic [EW-2:0]    sh_r, sh_nxt;
  logic [EW-1:0]    rem_r, rem_nxt;
  logic [QW-1:0]    q_r, q_nxt;
  logic [QW-1:0]    step_r, step_nxt;

  logic             dec_phase_r, dec_phase_nxt;
  logic [PW-1:0]    prefix_r, prefix_nxt;
  logic [PW-1:0]    idx_r, idx_nxt;
  logic [OUT_W-1:0] acc_r, acc_nxt;
  logic [OUT_W-1:0] mask_r, mask_nxt;
  logic [OUT_W-1:0] acc_bit;

  logic             out_valid_r;
  logic             code_r, bvalid_r, last_r, vvalid_r, err_r;
  logic [OUT_W-1:0] dval_r;

  logic             emit, code_nxt, bvalid_nxt, last_nxt, vvalid_nxt, err_nxt;
  logic [OUT_W-1:0] dval_nxt;

  logic [EW-1:0]    v_in;
  logic             can_load, accept, sh_more;

  assign v_in     = in_value_in[EW-1:0];
  assign can_load = !out_valid_r || !out_stall;
  assign in_stall = (enc_state_r != ENC_IDLE) || !can_load;
  assign accept   = in_valid && !in_stall;
  assign sh_more  = (sh_r != '0);
  assign acc_bit  = in_code_bit_in ? mask_r : '0;

  // encoder sequencing
  always_comb begin
    enc_state_nxt = enc_state_r;
    unique case (enc_state_r)
      ENC_IDLE: begin
        if (accept && in_mode == MODE_ENCODE && v_in != '0) enc_state_nxt = ENC_PREFIX;
      end
      ENC_PREFIX: begin
        if (can_load && !sh_more) enc_state_nxt = (q_r == '0) ? ENC_IDLE : ENC_SUFFIX;
      end
      ENC_SUFFIX: begin
        if (can_load && step_r == q_r - 1'b1) enc_state_nxt = ENC_IDLE;
      end
      default: enc_state_nxt = ENC_IDLE;
    endcase
  end

  // datapath and result generation
  always_comb begin
    sh_nxt        = sh_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    step_nxt      = step_r;
    dec_phase_nxt = dec_phase_r;
    prefix_nxt    = prefix_r;
    idx_nxt       = idx_r;
    acc_nxt       = acc_r;
    mask_nxt      = mask_r;
    emit          = 1'b0;
    code_nxt      = 1'b0;
    bvalid_nxt    = 1'b0;
    last_nxt      = 1'b0;
    dval_nxt      = '0;
    vvalid_nxt    = 1'b0;
    err_nxt       = 1'b0;
    unique case (enc_state_r)
      ENC_IDLE: begin
        if (accept && in_mode == MODE_ENCODE) begin
          if (v_in == '0) begin
            emit    = 1'b1;
            err_nxt = 1'b1;
          end else begin
            sh_nxt   = v_in[EW-1:1];
            rem_nxt  = v_in;
            q_nxt    = '0;
            step_nxt = '0;
          end
        end else if (accept) begin
          if (!dec_phase_r) begin
            if (in_code_bit_in) begin
              if (prefix_r == PW'(VALUE_WIDTH - 1)) begin
                emit       = 1'b1;
                err_nxt    = 1'b1;
                prefix_nxt = '0;
              end else begin
                prefix_nxt = prefix_r + 1'b1;
              end
            end else if (prefix_r == '0) begin
              emit       = 1'b1;
              vvalid_nxt = 1'b1;
              dval_nxt   = OUT_W'(1);
            end else begin
              dec_phase_nxt = 1'b1;
              idx_nxt       = '0;
              acc_nxt       = '0;
              mask_nxt      = OUT_W'(1);
            end
          end else begin
            if (idx_r == prefix_r - 1'b1) begin
              emit          = 1'b1;
              vvalid_nxt    = 1'b1;
              dval_nxt      = acc_r | acc_bit | {mask_r[OUT_W-2:0], 1'b0};
              dec_phase_nxt = 1'b0;
              prefix_nxt    = '0;
              idx_nxt       = '0;
              acc_nxt       = '0;
            end else begin
              idx_nxt  = idx_r + 1'b1;
              acc_nxt  = acc_r | acc_bit;
              mask_nxt = {mask_r[OUT_W-2:0], 1'b0};
            end
          end
        end
      end
      ENC_PREFIX: begin
        if (can_load) begin
          emit       = 1'b1;
          bvalid_nxt = 1'b1;
          if (sh_more) begin
            code_nxt = 1'b1;
            sh_nxt   = sh_r >> 1;
            q_nxt    = q_r + 1'b1;
          end else begin
            last_nxt = (q_r == '0);
          end
        end
      end
      ENC_SUFFIX: begin
        if (can_load) begin
          emit       = 1'b1;
          bvalid_nxt = 1'b1;
          code_nxt   = rem_r[0];
          last_nxt   = (step_r == q_r - 1'b1);
          rem_nxt    = {1'b0, rem_r[EW-1:1]};
          step_nxt   = step_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enc_state_r <= ENC_IDLE;
      dec_phase_r <= 1'b0;
      prefix_r    <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      enc_state_r <= enc_state_nxt;
      dec_phase_r <= dec_phase_nxt;
      prefix_r    <= prefix_nxt;
      idx_r       <= idx_nxt;
      if (can_load) out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    sh_r   <= sh_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    step_r <= step_nxt;
    acc_r  <= acc_nxt;
    mask_r <= mask_nxt;
    if (can_load && emit) begin
      code_r   <= code_nxt;
      bvalid_r <= bvalid_nxt;
      last_r   <= last_nxt;
      dval_r   <= dval_nxt;
      vvalid_r <= vvalid_nxt;
      err_r    <= err_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_code_bit_out  = code_r;
  assign out_bit_valid     = bvalid_r;
  assign out_last_bit      = last_r;
  assign out_decoded_value = dval_r;
  assign out_value_valid   = vvalid_r;
  assign out_error         = err_r;

  `EGC_ASSERT_IMPL(a_kind_excl, out_valid_r, !(bvalid_r && vvalid_r) && !(err_r && (bvalid_r || vvalid_r)), "result item mixes kinds")
  `EGC_ASSERT_IMPL(a_last_is_bit, out_valid_r && last_r, bvalid_r, "last flag on a non-code item")
  `EGC_ASSERT_IMPL(a_suffix_prefix, dec_phase_r, prefix_r != '0, "decoder suffix phase with empty prefix")
  `EGC_ASSERT_IMPL(a_enc_step, enc_state_r == ENC_SUFFIX, step_r < q_r, "encoder suffix step overran q")
  `EGC_ASSERT_NEXT(a_enc_hold_dec, enc_state_r != ENC_IDLE, dec_phase_r == $past(dec_phase_r) && prefix_r == $past(prefix_r), "decoder moved during encode")

endmodule
